// ===== design/key_matrix_hid_report_builder_defines.svh =====
// Assertion helpers shared by the report builder modules.
// Each expects clk and rst_n in scope and is disabled while reset is low.
`ifndef KEY_MATRIX_HID_REPORT_BUILDER_DEFINES_SVH
`define KEY_MATRIX_HID_REPORT_BUILDER_DEFINES_SVH

// Condition must hold at every clock edge out of reset.
`define KMHID_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("kmhid assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define KMHID_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kmhid assertion failed");

`endif

// ===== design/kmhid_pkg.sv =====
package kmhid_pkg;

  localparam int SLOT_COUNT = 6;

  typedef logic [7:0] code_t;

  typedef enum logic [1:0] {
    FUNC_EVENT   = 2'd0,
    FUNC_RELEASE = 2'd1,
    FUNC_MAP     = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_KEY  = 2'd1,
    KIND_MOD  = 2'd2
  } kind_t;

  typedef struct packed {
    logic [1:0] func;
    logic [3:0] key_row;
    logic [4:0] key_col;
    logic       is_pressed;
    logic       map_layer;
    logic [1:0] action_kind;
    logic [7:0] action_code;
    logic       fn_position;
  } in_item_t;

  typedef struct packed {
    logic [7:0] modifier_bits;
    logic [7:0] slot_0;
    logic [7:0] slot_1;
    logic [7:0] slot_2;
    logic [7:0] slot_3;
    logic [7:0] slot_4;
    logic [7:0] slot_5;
    logic       active_layer;
    logic [2:0] filled_slots;
  } out_item_t;

  typedef struct packed {
    logic [1:0] kind;
    code_t      code;
  } act_t;

  // One matrix position: function-key mark, pressed state, both layers' actions.
  typedef struct packed {
    logic fn;
    logic pressed;
    act_t act_fn;
    act_t act_base;
  } pos_entry_t;

  typedef struct packed {
    logic       clr;
    logic       vld;
    logic [1:0] kind;
    code_t      code;
  } acc_in_t;

endpackage

// ===== design/kmhid_chan_if.sv =====
interface kmhid_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== design/kmhid_slot_acc.sv =====
`include "key_matrix_hid_report_builder_defines.svh"

module kmhid_slot_acc #(
  parameter int MAX_SLOTS = 6
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  kmhid_pkg::acc_in_t                            acc_in,
  output logic [7:0]                                    mods,
  output kmhid_pkg::code_t [kmhid_pkg::SLOT_COUNT-1:0] slots,
  output logic [2:0]                                    count
);
  import kmhid_pkg::*;

  logic [7:0]                  mods_r, mods_nxt;
  code_t [SLOT_COUNT-1:0]      slot_r, slot_nxt;
  logic [2:0]                  count_r, count_nxt;
  logic [SLOT_COUNT-1:0]       hit;

  // Compare against filled slots only: an empty slot reads 0 and must not match code 0.
  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      hit[i] = (3'(i) < count_r) && (slot_r[i] == acc_in.code);
    end
  end

  always_comb begin
    mods_nxt  = mods_r;
    slot_nxt  = slot_r;
    count_nxt = count_r;
    priority if (acc_in.clr) begin
      mods_nxt  = '0;
      slot_nxt  = '0;
      count_nxt = '0;
    end else if (acc_in.vld && acc_in.kind == KIND_MOD) begin
      mods_nxt = mods_r | acc_in.code;
    end else if (acc_in.vld && acc_in.kind == KIND_KEY &&
                 count_r < 3'(MAX_SLOTS) && !(|hit)) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (count_r == 3'(i)) begin
          slot_nxt[i] = acc_in.code;
        end
      end
      count_nxt = count_r + 3'd1;
    end else begin
      count_nxt = count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mods_r  <= '0;
      slot_r  <= '0;
      count_r <= '0;
    end else begin
      mods_r  <= mods_nxt;
      slot_r  <= slot_nxt;
      count_r <= count_nxt;
    end
  end

  assign mods  = mods_r;
  assign slots = slot_r;
  assign count = count_r;

  `KMHID_ALWAYS(acc_count_max, count_r <= 3'(MAX_SLOTS))
  `KMHID_NEXT(acc_clr_empties, acc_in.clr, count_r == 3'd0 && mods_r == 8'd0)
  `KMHID_NEXT(acc_count_step, !acc_in.clr, (count_r == $past(count_r)) || (count_r == $past(count_r) + 3'd1))
  `KMHID_NEXT(acc_mod_keeps_count, !acc_in.clr && acc_in.vld && acc_in.kind == KIND_MOD, count_r == $past(count_r))

endmodule

// ===== design/key_matrix_hid_report_builder.sv =====
// Key matrix to 6-key-rollover boot keyboard report builder. All matrix state
// (pressed bit, function-key mark and both keymap layers of every position)
// lives in one single-port-read, single-port-write memory of ROWS*COLS
// entries with a registered read port. After reset the block clears that
// memory entry by entry and takes no item meanwhile. A key event inside the
// matrix goes through these steps until its report is offered: one
// read-modify-write of the event's position, then two scans of the memory at
// one entry a cycle, the first to find whether a pressed function key selects
// the function layer, the second to gather modifiers and key codes. Release-all
// sweeps the memory to clear the pressed bits and reports an all-zero beat.
// A keymap write passes through the read-modify-write and gives no report; so
// do events outside the matrix and unknown commands, which are dropped in the
// accepting cycle. A new item is taken while the previous report still waits
// at the output; the next report then holds in its last cycle until the waiting
// one is taken.
`include "key_matrix_hid_report_builder_defines.svh"

module key_matrix_hid_report_builder #(
  parameter int ROWS      = 8,
  parameter int COLS      = 16,
  parameter int MAX_SLOTS = 6
) (
  input logic          clk,
  input logic          rst_n,
  kmhid_chan_if.sink   in_ch,
  kmhid_chan_if.source out_ch
);
  import kmhid_pkg::*;

  localparam int POSITIONS = ROWS * COLS;
  localparam int PW        = (POSITIONS > 1) ? $clog2(POSITIONS) : 1;
  localparam logic [PW-1:0] LAST_POS = PW'(POSITIONS - 1);

  typedef enum logic [6:0] {
    ST_INIT  = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_RMW   = 7'b0000100,
    ST_SCAN1 = 7'b0001000,
    ST_SCAN2 = 7'b0010000,
    ST_SWEEP = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_t;

  state_t          state_r, state_nxt;
  logic [PW-1:0]   addr_r, addr_nxt;
  logic            issue_r, issue_nxt;
  logic            vld_r, vld_nxt;
  logic            last_r, last_nxt;
  logic [PW-1:0]   paddr_r, paddr_nxt;
  logic            layer_r, layer_nxt;
  logic            fn_hit_r, fn_hit_nxt;
  logic            out_valid_r;
  out_item_t       out_r;
  logic            out_load;

  logic            op_map_r;
  logic [PW-1:0]   op_pos_r;
  logic            op_pressed_r;
  logic            op_layer_r;
  act_t            op_act_r;
  logic            op_fn_r;

  pos_entry_t      mem [POSITIONS];
  pos_entry_t      rdata_r;
  logic [PW-1:0]   mem_raddr;
  logic            mem_we;
  logic [PW-1:0]   mem_waddr;
  pos_entry_t      mem_wdata;

  logic            accept;
  logic            in_inside;
  logic [PW-1:0]   in_pos;
  act_t            in_act;
  logic            in_pass;
  logic            pass_done;

  acc_in_t                acc_in;
  logic [7:0]             acc_mods;
  code_t [SLOT_COUNT-1:0] acc_slots;
  logic [2:0]             acc_count;

  assign accept    = in_ch.valid && in_ch.ready;
  assign in_inside = ({1'b0, in_ch.payload.key_row} < 5'(ROWS)) &&
                     ({1'b0, in_ch.payload.key_col} < 6'(COLS));
  assign in_pos    = in_inside ? PW'(int'(in_ch.payload.key_row) * COLS +
                                     int'(in_ch.payload.key_col)) : '0;

  // Unknown action kind is stored as no action.
  always_comb begin
    in_act.code = in_ch.payload.action_code;
    if (in_ch.payload.action_kind == KIND_KEY || in_ch.payload.action_kind == KIND_MOD) begin
      in_act.kind = in_ch.payload.action_kind;
    end else begin
      in_act.kind = KIND_NONE;
    end
  end

  assign in_pass   = (state_r == ST_SCAN1) || (state_r == ST_SCAN2) || (state_r == ST_SWEEP);
  assign pass_done = vld_r && last_r;

  always_comb begin
    state_nxt  = state_r;
    addr_nxt   = addr_r;
    issue_nxt  = issue_r;
    vld_nxt    = 1'b0;
    last_nxt   = last_r;
    paddr_nxt  = paddr_r;
    layer_nxt  = layer_r;
    fn_hit_nxt = fn_hit_r;
    out_load   = 1'b0;
    mem_raddr  = addr_r;
    mem_we     = 1'b0;
    mem_waddr  = paddr_r;
    mem_wdata  = rdata_r;
    acc_in     = '{clr: 1'b0, vld: 1'b0, kind: KIND_NONE, code: '0};

    // Scan engine: issue one read a cycle; its data follows in the next cycle.
    if (in_pass && issue_r) begin
      vld_nxt   = 1'b1;
      last_nxt  = (addr_r == LAST_POS);
      paddr_nxt = addr_r;
      addr_nxt  = addr_r + 1'b1;
      if (addr_r == LAST_POS) begin
        issue_nxt = 1'b0;
      end
    end

    unique case (state_r)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = addr_r;
        mem_wdata = '0;
        addr_nxt  = addr_r + 1'b1;
        if (addr_r == LAST_POS) begin
          addr_nxt  = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        mem_raddr     = in_pos;
        acc_in.clr    = 1'b1;
        fn_hit_nxt    = 1'b0;
        if (accept) begin
          unique case (in_ch.payload.func)
            FUNC_EVENT, FUNC_MAP: begin
              if (in_inside) begin
                state_nxt = ST_RMW;
              end
            end
            FUNC_RELEASE: begin
              layer_nxt = 1'b0;
              addr_nxt  = '0;
              issue_nxt = 1'b1;
              state_nxt = ST_SWEEP;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_RMW: begin
        mem_we    = 1'b1;
        mem_waddr = op_pos_r;
        if (op_map_r) begin
          mem_wdata.fn = op_fn_r;
          if (op_layer_r) begin
            mem_wdata.act_fn = op_act_r;
          end else begin
            mem_wdata.act_base = op_act_r;
          end
          state_nxt = ST_IDLE;
        end else begin
          mem_wdata.pressed = op_pressed_r;
          addr_nxt  = '0;
          issue_nxt = 1'b1;
          state_nxt = ST_SCAN1;
        end
      end
      ST_SCAN1: begin
        if (vld_r) begin
          fn_hit_nxt = fn_hit_r | (rdata_r.pressed & rdata_r.fn);
        end
        if (pass_done) begin
          layer_nxt = fn_hit_nxt;
          addr_nxt  = '0;
          issue_nxt = 1'b1;
          state_nxt = ST_SCAN2;
        end
      end
      ST_SCAN2: begin
        acc_in.vld  = vld_r && rdata_r.pressed;
        acc_in.kind = layer_r ? rdata_r.act_fn.kind : rdata_r.act_base.kind;
        acc_in.code = layer_r ? rdata_r.act_fn.code : rdata_r.act_base.code;
        if (pass_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_SWEEP: begin
        // Write each entry back with its pressed bit dropped.
        if (vld_r) begin
          mem_we            = 1'b1;
          mem_waddr         = paddr_r;
          mem_wdata.pressed = 1'b0;
        end
        if (pass_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      addr_r      <= '0;
      issue_r     <= 1'b0;
      vld_r       <= 1'b0;
      last_r      <= 1'b0;
      layer_r     <= 1'b0;
      fn_hit_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      addr_r   <= addr_nxt;
      issue_r  <= issue_nxt;
      vld_r    <= vld_nxt;
      last_r   <= last_nxt;
      layer_r  <= layer_nxt;
      fn_hit_r <= fn_hit_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    paddr_r <= paddr_nxt;
    if (accept) begin
      op_map_r     <= (in_ch.payload.func == FUNC_MAP);
      op_pos_r     <= in_pos;
      op_pressed_r <= in_ch.payload.is_pressed;
      op_layer_r   <= in_ch.payload.map_layer;
      op_act_r     <= in_act;
      op_fn_r      <= in_ch.payload.fn_position;
    end
    if (out_load) begin
      out_r.modifier_bits <= acc_mods;
      out_r.slot_0        <= acc_slots[0];
      out_r.slot_1        <= acc_slots[1];
      out_r.slot_2        <= acc_slots[2];
      out_r.slot_3        <= acc_slots[3];
      out_r.slot_4        <= acc_slots[4];
      out_r.slot_5        <= acc_slots[5];
      out_r.active_layer  <= layer_r;
      out_r.filled_slots  <= acc_count;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  kmhid_slot_acc #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_slot_acc (
    .clk    (clk),
    .rst_n  (rst_n),
    .acc_in (acc_in),
    .mods   (acc_mods),
    .slots  (acc_slots),
    .count  (acc_count)
  );

  assign in_ch.ready    = (state_r == ST_IDLE);
  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = out_r;

  `KMHID_ALWAYS(top_vld_in_pass, !vld_r || in_pass)
  `KMHID_ALWAYS(top_no_write_in_scan, !(mem_we && (state_r == ST_SCAN1 || state_r == ST_SCAN2)))
  `KMHID_NEXT(top_done_holds, state_r == ST_DONE && out_valid_r && !out_ch.ready, state_r == ST_DONE)
  `KMHID_NEXT(top_release_clears_layer, accept && in_ch.payload.func == FUNC_RELEASE, layer_r == 1'b0 && state_r == ST_SWEEP)

endmodule

// ===== sim/key_matrix_hid_report_builder_test.sv =====
`timescale 1ns / 1ps

module key_matrix_hid_report_builder_test;
  import kmhid_pkg::*;

  localparam int ROWS      = 8;
  localparam int COLS      = 16;
  localparam int MAX_SLOTS = 6;
  localparam int POSITIONS = ROWS * COLS;
  localparam int TARGET_ITEMS = 950;
  localparam int DRAIN_CYCLES = 600;
  localparam int HOLD_CYCLES  = 3000;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  logic clk;
  logic rst_n;

  kmhid_chan_if #(.payload_t(in_item_t))  in_ch ();
  kmhid_chan_if #(.payload_t(out_item_t)) out_ch ();

  key_matrix_hid_report_builder #(
    .ROWS      (ROWS),
    .COLS      (COLS),
    .MAX_SLOTS (MAX_SLOTS)
  ) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Predicted keyboard state
  bit    key_down [POSITIONS];
  bit    fn_mark  [POSITIONS];
  kind_t key_kind [2][POSITIONS];
  code_t key_code [2][POSITIONS];

  in_item_t  key_items_pending [$];
  out_item_t expected_reports  [$];

  int  in_pushed;
  int  in_taken;
  int  mismatch_count;
  int  in_idle_pct;
  int  out_stall_pct;
  bit  in_beat_taken;
  bit  hold_off;

  function automatic out_item_t scan_report();
    out_item_t rpt;
    code_t     slot [SLOT_COUNT];
    int        filled;
    bit        layer;
    bit        dup;
    rpt    = '0;
    filled = 0;
    layer  = 1'b0;
    for (int s = 0; s < SLOT_COUNT; s++) slot[s] = '0;
    for (int p = 0; p < POSITIONS; p++) begin
      if (key_down[p] && fn_mark[p]) layer = 1'b1;
    end
    for (int p = 0; p < POSITIONS; p++) begin
      if (key_down[p]) begin
        if (key_kind[layer][p] == KIND_MOD) begin
          rpt.modifier_bits = rpt.modifier_bits | key_code[layer][p];
        end else if (key_kind[layer][p] == KIND_KEY && filled < MAX_SLOTS) begin
          dup = 1'b0;
          for (int s = 0; s < filled; s++) begin
            if (slot[s] == key_code[layer][p]) dup = 1'b1;
          end
          if (!dup) begin
            slot[filled] = key_code[layer][p];
            filled++;
          end
        end
      end
    end
    rpt.slot_0       = slot[0];
    rpt.slot_1       = slot[1];
    rpt.slot_2       = slot[2];
    rpt.slot_3       = slot[3];
    rpt.slot_4       = slot[4];
    rpt.slot_5       = slot[5];
    rpt.active_layer = layer;
    rpt.filled_slots = 3'(filled);
    return rpt;
  endfunction

  task automatic take_key_item(input in_item_t it);
    bit in_matrix;
    int pos;
    in_matrix = (it.key_row < ROWS) && (it.key_col < COLS);
    pos       = int'(it.key_row) * COLS + int'(it.key_col);
    case (it.func)
      FUNC_EVENT: begin
        if (in_matrix) begin
          key_down[pos] = it.is_pressed;
          expected_reports.push_back(scan_report());
        end
      end
      FUNC_RELEASE: begin
        for (int p = 0; p < POSITIONS; p++) key_down[p] = 1'b0;
        expected_reports.push_back('0);
      end
      FUNC_MAP: begin
        if (in_matrix) begin
          key_kind[it.map_layer][pos] =
            (it.action_kind > KIND_MOD) ? KIND_NONE : kind_t'(it.action_kind);
          key_code[it.map_layer][pos] = it.action_code;
          fn_mark[pos] = it.fn_position;
        end
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what, input out_item_t want,
                                 input out_item_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t %s: want mod=%h slots=%h %h %h %h %h %h layer=%0d n=%0d",
               $realtime, what, want.modifier_bits, want.slot_0, want.slot_1,
               want.slot_2, want.slot_3, want.slot_4, want.slot_5,
               want.active_layer, want.filled_slots);
      $display("    got mod=%h slots=%h %h %h %h %h %h layer=%0d n=%0d",
               got.modifier_bits, got.slot_0, got.slot_1, got.slot_2,
               got.slot_3, got.slot_4, got.slot_5, got.active_layer,
               got.filled_slots);
    end
  endtask

  function automatic in_item_t mk(input logic [1:0] f, input int row, input int col,
                                  input bit pressed, input bit layer,
                                  input logic [1:0] kind, input code_t code,
                                  input bit fn);
    in_item_t it;
    it.func        = f;
    it.key_row     = 4'(row);
    it.key_col     = 5'(col);
    it.is_pressed  = pressed;
    it.map_layer   = layer;
    it.action_kind = kind;
    it.action_code = code;
    it.fn_position = fn;
    return it;
  endfunction

  task automatic push_item(input in_item_t it);
    key_items_pending.push_back(it);
    in_pushed++;
  endtask

  // Most traffic lands on the first two rows so that mapped keys get pressed.
  function automatic in_item_t random_key_item(output bit ignored);
    in_item_t it;
    int       pick;
    int       which;
    it      = in_item_t'($urandom);
    ignored = 1'b0;
    pick    = $urandom_range(99);
    it.key_row = ($urandom_range(99) < 70) ? 4'($urandom_range(1))
                                           : 4'($urandom_range(ROWS - 1));
    it.key_col = 5'($urandom_range(COLS - 1));
    if (pick < 55) begin
      it.func       = FUNC_EVENT;
      it.is_pressed = ($urandom_range(99) < 60);
    end else if (pick < 60) begin
      it.func = FUNC_RELEASE;
    end else if (pick < 92) begin
      it.func        = FUNC_MAP;
      it.action_kind = 2'($urandom_range(3));
      it.action_code = ($urandom_range(1) != 0) ? code_t'($urandom_range(7))
                                                : code_t'($urandom_range(255));
      it.fn_position = ($urandom_range(99) < 12);
    end else begin
      ignored = 1'b1;
      case ($urandom_range(2))
        0:       it.func = FUNC_UNUSED;
        1:       it.func = FUNC_EVENT;
        default: it.func = FUNC_MAP;
      endcase
      if (it.func != FUNC_UNUSED) begin
        which = $urandom_range(2);
        if (which != 1) it.key_row = 4'($urandom_range(15, ROWS));
        if (which != 0) it.key_col = 5'($urandom_range(31, COLS));
      end
    end
    return it;
  endfunction

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.payload  = '0;
    out_ch.ready   = 1'b0;
    in_pushed      = 0;
    in_taken       = 0;
    mismatch_count = 0;
    in_idle_pct    = 0;
    out_stall_pct  = 0;
    in_beat_taken  = 1'b0;
    hold_off       = 1'b0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
  end

  // Driver: hold the beat until taken, then offer the next or idle
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_beat_taken) begin
      in_beat_taken = 1'b0;
      if (key_items_pending.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
        in_ch.payload <= key_items_pending.pop_front();
        in_ch.valid   <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n || hold_off) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  // Monitor: check the result beat before predicting from the input beat
  always @(posedge clk) begin : monitor
    out_item_t want;
    out_item_t got;
    if (!rst_n) begin
      for (int p = 0; p < POSITIONS; p++) begin
        key_down[p] = 1'b0;
        fn_mark[p]  = 1'b0;
        for (int l = 0; l < 2; l++) begin
          key_kind[l][p] = KIND_NONE;
          key_code[l][p] = '0;
        end
      end
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.payload;
        if (expected_reports.size() == 0) begin
          report_mismatch("unexpected report", '0, got);
        end else begin
          want = expected_reports.pop_front();
          if (got.modifier_bits !== want.modifier_bits || got.slot_0 !== want.slot_0 ||
              got.slot_1 !== want.slot_1 || got.slot_2 !== want.slot_2 ||
              got.slot_3 !== want.slot_3 || got.slot_4 !== want.slot_4 ||
              got.slot_5 !== want.slot_5 || got.active_layer !== want.active_layer ||
              got.filled_slots !== want.filled_slots) begin
            report_mismatch("report mismatch", want, got);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        take_key_item(in_ch.payload);
        in_taken++;
        in_beat_taken = 1'b1;
      end
    end
  end

  // Hold the receiver off long enough for the block to back up its input
  initial begin
    wait (in_taken >= 150);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off = 1'b0;
  end

  initial begin : stimulus
    in_item_t it;
    bit       ignored;
    int       done;
    int       phase_end;
    @(posedge rst_n);

    push_item(mk(FUNC_RELEASE, 0, 0, 1'b0, 1'b0, KIND_NONE, 8'h00, 1'b0));
    push_item(mk(FUNC_MAP, 0, 2, 1'b0, 1'b0, KIND_MOD, 8'hFF, 1'b0));
    push_item(mk(FUNC_MAP, 7, 15, 1'b0, 1'b0, KIND_UNUSED, 8'hAA, 1'b0));
    push_item(mk(FUNC_MAP, 7, 15, 1'b1, 1'b1, KIND_KEY, 8'hFF, 1'b1));
    // Outside the matrix and unknown commands: dropped
    push_item(mk(FUNC_MAP, 15, 31, 1'b1, 1'b1, KIND_KEY, 8'h12, 1'b1));
    push_item(mk(FUNC_EVENT, 8, 0, 1'b1, 1'b0, KIND_NONE, 8'h00, 1'b0));
    push_item(mk(FUNC_EVENT, 0, 16, 1'b1, 1'b0, KIND_NONE, 8'h00, 1'b0));
    push_item(mk(FUNC_UNUSED, 15, 31, 1'b1, 1'b1, KIND_UNUSED, 8'hFF, 1'b1));
    push_item(mk(FUNC_EVENT, 0, 2, 1'b1, 1'b0, KIND_NONE, 8'h00, 1'b0));
    // Eight key codes with a zero code and a duplicate: the last one drops
    for (int c = 0; c < 8; c++) begin
      push_item(mk(FUNC_MAP, 1, c, 1'b0, 1'b0, KIND_KEY,
                   (c == 0) ? 8'h00 : (c == 1) ? 8'h04 : code_t'(c + 2), 1'b0));
    end
    for (int c = 0; c < 8; c++) begin
      push_item(mk(FUNC_EVENT, 1, c, 1'b1, 1'b0, KIND_NONE, 8'h00, 1'b0));
    end
    push_item(mk(FUNC_EVENT, 7, 15, 1'b1, 1'b0, KIND_NONE, 8'h00, 1'b0));
    push_item(mk(FUNC_EVENT, 7, 15, 1'b0, 1'b0, KIND_NONE, 8'h00, 1'b0));
    push_item(mk(FUNC_RELEASE, 0, 0, 1'b0, 1'b0, KIND_NONE, 8'h00, 1'b0));

    done = 0;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1:       begin in_idle_pct = 56; out_stall_pct = 0;  end
        2:       begin in_idle_pct = 0;  out_stall_pct = 56; end
        default: begin in_idle_pct = 34; out_stall_pct = 34; end
      endcase
      phase_end = (phase == 3) ? TARGET_ITEMS : done + TARGET_ITEMS / 4;
      while (done < phase_end) begin
        it = random_key_item(ignored);
        push_item(it);
        if (!ignored) done++;
      end
      while (in_taken != in_pushed) @(posedge clk);
    end

    while (expected_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_reports.size() == 0) begin
      $display("key_matrix_hid_report_builder verification clean");
    end else begin
      $display("key_matrix_hid_report_builder verification failed");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("key_matrix_hid_report_builder verification failed");
    $finish;
  end

endmodule
